[sv/nvs_pkg.sv]
// ----------------------------------------------------------------------------
// nvs_pkg
// Shared request and response types and fixed field widths of the nearest
// vector search block.
// ----------------------------------------------------------------------------
package nvs_pkg;

  // Fixed field widths of the request and response
  localparam int unsigned IN_COMPONENTS = 4;
  localparam int unsigned IN_BITS       = 16;
  localparam int unsigned INDEX_BITS    = 6;
  localparam int unsigned DIST_BITS     = 34;
  localparam int unsigned USE_BITS      = 7;

  // Command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic                  command;
    logic [INDEX_BITS-1:0] entry_index;
    logic [IN_BITS-1:0]    component_0;
    logic [IN_BITS-1:0]    component_1;
    logic [IN_BITS-1:0]    component_2;
    logic [IN_BITS-1:0]    component_3;
  } req_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] best_index;
    logic [DIST_BITS-1:0]  best_distance_sq;
    logic                  found;
  } rsp_t;

endpackage

[sv/nvs_dist.sv]
// ----------------------------------------------------------------------------
// nvs_dist
// Three-stage squared Euclidean distance pipeline: absolute difference per
// component, square per component, sum over components. One entry per cycle.
// ----------------------------------------------------------------------------
module nvs_dist #(
  parameter int unsigned DIMENSIONS     = 4,
  parameter int unsigned COMPONENT_BITS = 16,
  parameter int unsigned TAG_BITS       = 6,
  localparam int unsigned ROW_BITS      = DIMENSIONS * COMPONENT_BITS,
  localparam int unsigned SQ_BITS       = 2 * COMPONENT_BITS,
  localparam int unsigned SUM_BITS      = SQ_BITS + $clog2(DIMENSIONS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic                last_i,
  input  logic [TAG_BITS-1:0] tag_i,
  input  logic [ROW_BITS-1:0] entry_i,
  input  logic [ROW_BITS-1:0] query_i,
  output logic                valid_o,
  output logic                last_o,
  output logic [TAG_BITS-1:0] tag_o,
  output logic [SUM_BITS-1:0] sum_o
);

  logic [COMPONENT_BITS-1:0] diff_d [DIMENSIONS];
  logic [COMPONENT_BITS-1:0] diff_q [DIMENSIONS];
  logic [SQ_BITS-1:0]        sq_d   [DIMENSIONS];
  logic [SQ_BITS-1:0]        sq_q   [DIMENSIONS];
  logic [SUM_BITS-1:0]       sum_d, sum_q;

  logic                vld1_q, vld2_q, vld3_q;
  logic                lst1_q, lst2_q, lst3_q;
  logic [TAG_BITS-1:0] tag1_q, tag2_q, tag3_q;

  // Stage 1: absolute difference per lane
  always_comb begin
    for (int d = 0; d < DIMENSIONS; d++) begin
      if (entry_i[d*COMPONENT_BITS +: COMPONENT_BITS] >=
          query_i[d*COMPONENT_BITS +: COMPONENT_BITS]) begin
        diff_d[d] = entry_i[d*COMPONENT_BITS +: COMPONENT_BITS] -
                    query_i[d*COMPONENT_BITS +: COMPONENT_BITS];
      end else begin
        diff_d[d] = query_i[d*COMPONENT_BITS +: COMPONENT_BITS] -
                    entry_i[d*COMPONENT_BITS +: COMPONENT_BITS];
      end
    end
  end

  // Stage 2: square per lane
  always_comb begin
    for (int d = 0; d < DIMENSIONS; d++) begin
      sq_d[d] = SQ_BITS'(diff_q[d]) * SQ_BITS'(diff_q[d]);
    end
  end

  // Stage 3: sum over lanes
  always_comb begin
    sum_d = '0;
    for (int d = 0; d < DIMENSIONS; d++) begin
      sum_d = sum_d + SUM_BITS'(sq_q[d]);
    end
  end

  // Data pipeline
  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    sq_q   <= sq_d;
    sum_q  <= sum_d;
    tag1_q <= tag_i;
    tag2_q <= tag1_q;
    tag3_q <= tag2_q;
  end

  // Valid and last tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      lst1_q <= 1'b0;
      lst2_q <= 1'b0;
      lst3_q <= 1'b0;
    end else begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      lst1_q <= valid_i && last_i;
      lst2_q <= lst1_q;
      lst3_q <= lst2_q;
    end
  end

  assign valid_o = vld3_q;
  assign last_o  = lst3_q;
  assign tag_o   = tag3_q;
  assign sum_o   = sum_q;

endmodule

[sv/nearest_vector_search.sv]
// ----------------------------------------------------------------------------
// nearest_vector_search
// Brute-force nearest neighbor search under squared Euclidean distance over
// a table of reference vectors held in a synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low. A load
//   request (command = load) writes one table row in that same edge and
//   leaves busy low, so a new request may follow in the next cycle. A load
//   to a slot at or above MAX_ENTRIES is dropped.
//   A query request scans rows 0 .. N-1, N = entries_in_use saturated to
//   MAX_ENTRIES. The row memory is read one row per cycle, and a query keeps
//   busy high until the scan ends; the result is shown with rsp_valid_o for
//   one cycle in the cycle busy drops. With N = 0 the result (found = 0)
//   comes in the cycle after the request and busy never rises. Ties go to
//   the lowest index. entries_in_use is written through cfg_we_i /
//   cfg_wdata_i; the user must do so only while idle, which the block does
//   not enforce. Reset clears entries_in_use and the controller; the table
//   is undefined until loaded and gets no clearing pass. The receiver cannot
//   stall; the result register holds until the next query overwrites it.
// ----------------------------------------------------------------------------
module nearest_vector_search #(
  parameter int unsigned MAX_ENTRIES    = 64,
  parameter int unsigned DIMENSIONS     = 4,
  parameter int unsigned COMPONENT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  nvs_pkg::req_t                 req_i,
  input  logic                          cfg_we_i,
  input  logic [nvs_pkg::USE_BITS-1:0]  cfg_wdata_i,
  output logic                          rsp_valid_o,
  output nvs_pkg::rsp_t                 rsp_o
);

  localparam int unsigned IDX_BITS = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_BITS = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMP_BITS = (CNT_BITS > nvs_pkg::USE_BITS) ? CNT_BITS
                                                                    : nvs_pkg::USE_BITS;
  localparam int unsigned ROW_BITS = DIMENSIONS * COMPONENT_BITS;
  localparam int unsigned SUM_BITS = 2 * COMPONENT_BITS + $clog2(DIMENSIONS);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_READ  = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [nvs_pkg::USE_BITS-1:0] entries_q;
  logic [ROW_BITS-1:0]          qvec_d, qvec_q;
  logic [IDX_BITS-1:0]          last_idx_d, last_idx_q;
  logic [IDX_BITS-1:0]          rd_idx_q, rd_idx_d;
  logic                         rd_en;

  logic                         accept, is_load, is_query;
  logic [CMP_BITS-1:0]          use_ext, count, count_m1, slot_ext;
  logic                         wr_en;
  logic [IDX_BITS-1:0]          wr_addr;

  logic [ROW_BITS-1:0]          mem_q [MAX_ENTRIES];
  logic [ROW_BITS-1:0]          rdata_q;
  logic                         rd_vld_q, rd_last_q;
  logic [IDX_BITS-1:0]          rd_tag_q;

  logic                         dist_vld, dist_last;
  logic [IDX_BITS-1:0]          dist_tag;
  logic [SUM_BITS-1:0]          dist_sum;

  logic [SUM_BITS-1:0]          best_sum_q, best_sum_d;
  logic [IDX_BITS-1:0]          best_idx_q, best_idx_d;
  logic                         take;

  logic [nvs_pkg::INDEX_BITS+IDX_BITS-1:0] idx_ext;
  logic [nvs_pkg::DIST_BITS+SUM_BITS-1:0]  sum_ext;

  nvs_pkg::rsp_t rsp_d, rsp_q;
  logic          rsp_we, rsp_valid_q;

  // Request decode
  assign accept   = start && !busy;
  assign is_load  = accept && (req_i.command == nvs_pkg::CMD_LOAD);
  assign is_query = accept && (req_i.command == nvs_pkg::CMD_QUERY);

  // Input vector, resized to the stored component width
  logic [nvs_pkg::IN_BITS-1:0] in_comp [nvs_pkg::IN_COMPONENTS];
  assign in_comp[0] = req_i.component_0;
  assign in_comp[1] = req_i.component_1;
  assign in_comp[2] = req_i.component_2;
  assign in_comp[3] = req_i.component_3;

  for (genvar g = 0; g < DIMENSIONS; g++) begin : g_vec
    if (g < nvs_pkg::IN_COMPONENTS) begin : g_in
      logic [nvs_pkg::IN_BITS+COMPONENT_BITS-1:0] comp_ext;
      assign comp_ext = {{COMPONENT_BITS{1'b0}}, in_comp[g]};
      assign qvec_d[g*COMPONENT_BITS +: COMPONENT_BITS] = comp_ext[COMPONENT_BITS-1:0];
    end else begin : g_zero
      assign qvec_d[g*COMPONENT_BITS +: COMPONENT_BITS] = '0;
    end
  end

  // Scan length, saturated to the table size
  always_comb begin
    use_ext = CMP_BITS'(entries_q);
    if (use_ext > CMP_BITS'(MAX_ENTRIES)) begin
      count = CMP_BITS'(MAX_ENTRIES);
    end else begin
      count = use_ext;
    end
    count_m1   = count - CMP_BITS'(1);
    last_idx_d = count_m1[IDX_BITS-1:0];
  end

  // Load path
  assign slot_ext = CMP_BITS'(req_i.entry_index);
  assign wr_en    = is_load && (slot_ext < CMP_BITS'(MAX_ENTRIES));
  assign wr_addr  = slot_ext[IDX_BITS-1:0];

  // Row memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= qvec_d;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_idx_q];
    end
  end

  // Controller
  always_comb begin
    state_d  = state_q;
    rd_idx_d = rd_idx_q;
    rd_en    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        rd_idx_d = '0;
        if (is_query && (count != '0)) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        rd_en    = 1'b1;
        rd_idx_d = rd_idx_q + IDX_BITS'(1);
        if (rd_idx_q == last_idx_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (dist_vld && dist_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      entries_q <= '0;
      rd_idx_q  <= '0;
      rd_vld_q  <= 1'b0;
      rd_last_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_idx_q  <= rd_idx_d;
      rd_vld_q  <= rd_en;
      rd_last_q <= rd_en && (rd_idx_q == last_idx_q);
      if (cfg_we_i) begin
        entries_q <= cfg_wdata_i;
      end
    end
  end

  // Query operands held for the scan
  always_ff @(posedge clk_i) begin
    rd_tag_q <= rd_idx_q;
    if (is_query) begin
      qvec_q     <= qvec_d;
      last_idx_q <= last_idx_d;
    end
  end

  // Distance pipeline
  nvs_dist #(
    .DIMENSIONS     (DIMENSIONS),
    .COMPONENT_BITS (COMPONENT_BITS),
    .TAG_BITS       (IDX_BITS)
  ) u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rd_vld_q),
    .last_i  (rd_last_q),
    .tag_i   (rd_tag_q),
    .entry_i (rdata_q),
    .query_i (qvec_q),
    .valid_o (dist_vld),
    .last_o  (dist_last),
    .tag_o   (dist_tag),
    .sum_o   (dist_sum)
  );

  // Running minimum; first row always taken, strict less keeps lowest index
  always_comb begin
    take       = dist_vld && ((dist_tag == '0) || (dist_sum < best_sum_q));
    best_sum_d = take ? dist_sum : best_sum_q;
    best_idx_d = take ? dist_tag : best_idx_q;
  end

  always_ff @(posedge clk_i) begin
    best_sum_q <= best_sum_d;
    best_idx_q <= best_idx_d;
  end

  // Result: end of scan, or empty scan
  always_comb begin
    idx_ext = {{nvs_pkg::INDEX_BITS{1'b0}}, best_idx_d};
    sum_ext = {{nvs_pkg::DIST_BITS{1'b0}}, best_sum_d};
    rsp_we  = 1'b0;
    rsp_d   = '0;
    if (dist_vld && dist_last) begin
      rsp_we                 = 1'b1;
      rsp_d.best_index       = idx_ext[nvs_pkg::INDEX_BITS-1:0];
      rsp_d.best_distance_sq = sum_ext[nvs_pkg::DIST_BITS-1:0];
      rsp_d.found            = 1'b1;
    end else if (is_query && (count == '0)) begin
      rsp_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_we) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_we;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule
